>>> design/optimal_split_strategy_dp_macros.svh
// Assertion macros used by the split strategy datapath.
`ifndef OPTIMAL_SPLIT_STRATEGY_DP_MACROS_SVH
`define OPTIMAL_SPLIT_STRATEGY_DP_MACROS_SVH
`ifndef SYNTH
`define OSDP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("osdp: same-cycle check failed");
`define OSDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("osdp: next-cycle check failed");
`else
`define OSDP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define OSDP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> design/osdp_pkg.sv
// Types and constants shared by the split strategy controller and datapath.
package osdp_pkg;

   localparam int COST_W    = 32;
   localparam int CFG_W     = 16;
   localparam int LEAF_W    = 7;
   localparam int SPLIT_W   = 6;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_MULT_COST = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EVAL_COST = 1'd1;

   typedef struct packed {
      logic load;
      logic cand_issue;
      logic size_commit;
      logic emit_init;
      logic node_read;
      logic pop_read;
      logic pop_load;
      logic out_emit;
      logic out_one;
   } osdp_cmd_type;

   typedef struct packed {
      logic n_one;
      logic cand_last;
      logic pipe_empty;
      logic size_last;
      logic cur_small;
      logic emit_last;
      logic out_free;
   } osdp_status_type;

endpackage

>>> design/osdp_ctrl.sv
// Controller state machine that sequences the table fill and the strategy walk.
module osdp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  osdp_pkg::osdp_status_type status_i,
   output osdp_pkg::osdp_cmd_type    cmd_o
);
   import osdp_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_CAND  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_NODE  = 3'd4;
   localparam logic [2:0] S_POP   = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;
   localparam logic [2:0] S_ONE   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd_o     = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_o.load = 1'b1;
               state_in   = S_START;
            end
         end
         S_START: begin
            state_in = status_i.n_one ? S_ONE : S_CAND;
         end
         S_CAND: begin
            cmd_o.cand_issue = 1'b1;
            if (status_i.cand_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // The best split of a size is final once the compare stages drain.
            if (status_i.pipe_empty) begin
               cmd_o.size_commit = 1'b1;
               if (status_i.size_last) begin
                  cmd_o.emit_init = 1'b1;
                  state_in        = S_NODE;
               end else begin
                  state_in = S_CAND;
               end
            end
         end
         S_NODE: begin
            if (status_i.cur_small) begin
               cmd_o.pop_read = 1'b1;
               state_in       = S_POP;
            end else begin
               cmd_o.node_read = 1'b1;
               state_in        = S_EMIT;
            end
         end
         S_POP: begin
            cmd_o.pop_load = 1'b1;
            state_in       = S_NODE;
         end
         S_EMIT: begin
            if (status_i.out_free) begin
               cmd_o.out_emit = 1'b1;
               state_in       = status_i.emit_last ? S_IDLE : S_NODE;
            end
         end
         S_ONE: begin
            if (status_i.out_free) begin
               cmd_o.out_one = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/osdp_datapath.sv
// Datapath: cost and split tables, candidate compare pipeline, subtree stack, result register.
`include "optimal_split_strategy_dp_macros.svh"
module osdp_datapath #(
   parameter int MAX_LEAVES = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [osdp_pkg::LEAF_W-1:0]           req_leaf_count,
   input  logic                                  csr_write_en,
   input  logic [osdp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [osdp_pkg::CFG_W-1:0]            csr_wdata,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [osdp_pkg::SPLIT_W-1:0]          rsp_split,
   output logic [osdp_pkg::SPLIT_W-1:0]          rsp_strategy_length,
   output logic                                  rsp_last,
   input  osdp_pkg::osdp_cmd_type                cmd_i,
   output osdp_pkg::osdp_status_type             status_o
);
   import osdp_pkg::*;

   localparam int SW  = $clog2(MAX_LEAVES + 1);
   localparam int AW  = $clog2(MAX_LEAVES);
   localparam int PRW = SW + CFG_W;
   localparam int TW  = COST_W + 2;

   // Configuration registers.
   logic [CFG_W-1:0] mult_cost_ff, mult_cost_in;
   logic [CFG_W-1:0] eval_cost_ff, eval_cost_in;

   always_comb begin
      mult_cost_in = mult_cost_ff;
      eval_cost_in = eval_cost_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MULT_COST: mult_cost_in = csr_wdata;
            CSR_EVAL_COST: eval_cost_in = csr_wdata;
            default: begin
               mult_cost_in = mult_cost_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_cost_ff <= CFG_W'(1);
         eval_cost_ff <= CFG_W'(1);
      end else begin
         mult_cost_ff <= mult_cost_in;
         eval_cost_ff <= eval_cost_in;
      end
   end

   // Leaf count, clamped to the range 1..MAX_LEAVES.
   logic [7:0]    leaf_ext;
   logic [SW-1:0] n_ff, n_in;
   logic [SW-1:0] size_ff, size_in;
   logic [SW-1:0] cand_ff, cand_in;

   assign leaf_ext = {1'b0, req_leaf_count};

   always_comb begin
      n_in    = n_ff;
      size_in = size_ff;
      cand_in = cand_ff;
      if (cmd_i.load) begin
         if (leaf_ext == 8'd0) begin
            n_in = SW'(1);
         end else if (leaf_ext > 8'(MAX_LEAVES)) begin
            n_in = SW'(MAX_LEAVES);
         end else begin
            n_in = SW'(leaf_ext);
         end
         size_in = SW'(2);
         cand_in = SW'(1);
      end else if (cmd_i.size_commit) begin
         size_in = size_ff + SW'(1);
         cand_in = SW'(1);
      end else if (cmd_i.cand_issue) begin
         cand_in = cand_ff + SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff    <= SW'(1);
         size_ff <= SW'(2);
         cand_ff <= SW'(1);
      end else begin
         n_ff    <= n_in;
         size_ff <= size_in;
         cand_ff <= cand_in;
      end
   end

   // Cost and split tables: one write port, cost has two registered read ports.
   logic [COST_W-1:0] cost_mem [MAX_LEAVES+1];
   logic [SW-1:0]     split_mem [MAX_LEAVES+1];
   logic              tbl_we;
   logic [SW-1:0]     tbl_waddr;
   logic [COST_W-1:0] best_cost_ff, best_cost_in;
   logic [SW-1:0]     best_split_ff, best_split_in;
   logic [COST_W-1:0] tbl_wcost;
   logic [SW-1:0]     tbl_wsplit;

   assign tbl_we     = cmd_i.load | cmd_i.size_commit;
   assign tbl_waddr  = cmd_i.load ? SW'(1) : size_ff;
   assign tbl_wcost  = cmd_i.load ? '0 : best_cost_ff;
   assign tbl_wsplit = cmd_i.load ? '0 : best_split_ff;

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         cost_mem[tbl_waddr]  <= tbl_wcost;
         split_mem[tbl_waddr] <= tbl_wsplit;
      end
   end

   // Stage A: table reads and the two weight products.
   logic [COST_W-1:0] rd_rest_ff, rd_cand_ff;
   logic [SW-1:0]     split_rd_ff;
   logic [PRW-1:0]    pm_ff, pm_in, pe_ff, pe_in;
   logic [SW-1:0]     cand_a_ff;
   logic              va_ff, va_in;
   logic [SW-1:0]     rest;

   assign rest  = size_ff - cand_ff;
   assign pm_in = PRW'(cand_ff) * PRW'(mult_cost_ff);
   assign pe_in = PRW'(rest) * PRW'(eval_cost_ff);
   assign va_in = cmd_i.cand_issue;

   always_ff @(posedge clock) begin
      if (cmd_i.cand_issue) begin
         rd_rest_ff <= cost_mem[rest];
         rd_cand_ff <= cost_mem[cand_ff];
      end
   end

   // The walk reads the split table at the current subtree size.
   logic [SW-1:0] cur_ff, cur_in;

   always_ff @(posedge clock) begin
      if (cmd_i.node_read) begin
         split_rd_ff <= split_mem[cur_ff];
      end
   end

   always_ff @(posedge clock) begin
      pm_ff     <= pm_in;
      pe_ff     <= pe_in;
      cand_a_ff <= cand_ff;
   end

   // Stage B: pairwise sums.
   logic [COST_W:0] sc_ff, sc_in;
   logic [PRW:0]    sp_ff, sp_in;
   logic [SW-1:0]   cand_b_ff;
   logic            vb_ff, vb_in;

   assign sc_in = (COST_W + 1)'(rd_rest_ff) + (COST_W + 1)'(rd_cand_ff);
   assign sp_in = (PRW + 1)'(pm_ff) + (PRW + 1)'(pe_ff);
   assign vb_in = va_ff;

   always_ff @(posedge clock) begin
      sc_ff     <= sc_in;
      sp_ff     <= sp_in;
      cand_b_ff <= cand_a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
      end
   end

   // Stage C: final add with saturation and the running minimum.
   // The first split of a size always loads; later ones win only if strictly cheaper.
   logic [TW-1:0]     total;
   logic [COST_W-1:0] total_sat;

   assign total     = TW'(sc_ff) + TW'(sp_ff);
   assign total_sat = (|total[TW-1:COST_W]) ? '1 : total[COST_W-1:0];

   always_comb begin
      best_cost_in  = best_cost_ff;
      best_split_in = best_split_ff;
      if (vb_ff && (cand_b_ff == SW'(1) || total_sat < best_cost_ff)) begin
         best_cost_in  = total_sat;
         best_split_in = cand_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_cost_ff  <= '0;
         best_split_ff <= '0;
      end else begin
         best_cost_ff  <= best_cost_in;
         best_split_ff <= best_split_in;
      end
   end

   // Preorder walk: the current subtree is held in a register and only
   // left parts of two or more leaves are pushed.
   logic [SW-1:0] stack_mem [MAX_LEAVES];
   logic [SW-1:0] stk_rd_ff;
   logic [SW-1:0] sp_cnt_ff, sp_cnt_in;
   logic [SW-1:0] sp_dec;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] b_sel;
   logic          push;

   assign sp_dec = sp_cnt_ff - SW'(1);
   assign b_sel  = (split_rd_ff == '0 || split_rd_ff >= cur_ff) ? SW'(1) : split_rd_ff;
   assign push   = cmd_i.out_emit && (b_sel >= SW'(2));

   always_ff @(posedge clock) begin
      if (push) begin
         stack_mem[sp_cnt_ff[AW-1:0]] <= b_sel;
      end
      if (cmd_i.pop_read) begin
         stk_rd_ff <= stack_mem[sp_dec[AW-1:0]];
      end
   end

   always_comb begin
      cur_in    = cur_ff;
      sp_cnt_in = sp_cnt_ff;
      cnt_in    = cnt_ff;
      if (cmd_i.emit_init) begin
         cur_in    = n_ff;
         sp_cnt_in = '0;
         cnt_in    = '0;
      end else if (cmd_i.out_emit) begin
         cur_in = cur_ff - b_sel;
         cnt_in = cnt_ff + SW'(1);
         if (push) begin
            sp_cnt_in = sp_cnt_ff + SW'(1);
         end
      end else if (cmd_i.pop_read) begin
         sp_cnt_in = sp_dec;
      end else if (cmd_i.pop_load) begin
         cur_in = stk_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff    <= SW'(1);
         sp_cnt_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cur_ff    <= cur_in;
         sp_cnt_ff <= sp_cnt_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SPLIT_W-1:0] rsp_split_ff, rsp_split_in;
   logic [SPLIT_W-1:0] rsp_len_ff, rsp_len_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [SW-1:0]      len_full;
   logic               emit_last;

   assign len_full  = n_ff - SW'(1);
   assign emit_last = ((SW + 1)'(cnt_ff) + (SW + 1)'(2)) == (SW + 1)'(n_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_split_in = rsp_split_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd_i.out_emit) begin
         rsp_valid_in = 1'b1;
         rsp_split_in = SPLIT_W'(b_sel);
         rsp_len_in   = SPLIT_W'(len_full);
         rsp_last_in  = emit_last;
      end else if (cmd_i.out_one) begin
         rsp_valid_in = 1'b1;
         rsp_split_in = '0;
         rsp_len_in   = '0;
         rsp_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_split_ff <= rsp_split_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_split           = rsp_split_ff;
   assign rsp_strategy_length = rsp_len_ff;
   assign rsp_last            = rsp_last_ff;

   assign status_o.n_one      = (n_ff == SW'(1));
   assign status_o.cand_last  = (cand_ff == size_ff - SW'(1));
   assign status_o.pipe_empty = ~va_ff & ~vb_ff;
   assign status_o.size_last  = (size_ff == n_ff);
   assign status_o.cur_small  = (cur_ff < SW'(2));
   assign status_o.emit_last  = emit_last;
   assign status_o.out_free   = ~rsp_valid_ff | rsp_ready;

   `OSDP_ASSERT_IMPL(a_cand_in_range, clock, reset, cmd_i.cand_issue, (cand_ff != '0) && (cand_ff < size_ff))
   `OSDP_ASSERT_IMPL(a_commit_drained, clock, reset, cmd_i.size_commit, !va_ff && !vb_ff)
   `OSDP_ASSERT_IMPL(a_popped_internal, clock, reset, cmd_i.pop_load, stk_rd_ff >= SW'(2))
   `OSDP_ASSERT_IMPL(a_cur_bounded, clock, reset, 1'b1, cur_ff <= n_ff)
   `OSDP_ASSERT_NEXT(a_walk_complete, clock, reset, cmd_i.out_emit && emit_last, (cur_ff == SW'(1)) && (sp_cnt_ff == '0))

endmodule

>>> design/optimal_split_strategy_dp.sv
// Top level of the optimal split strategy engine: controller plus datapath.
// A request of leaf count n (0 is taken as 1, values above MAX_LEAVES as MAX_LEAVES) first
// fills the cost and split tables for sizes 2..n by evaluating one candidate split per cycle
// through a three-stage compare pipeline, which drains before the table write of each size.
// The preorder walk then reads the split table once per entry and returns n-1 responses,
// each held back while the output register is full, and takes subtrees back from the stack;
// a request of one leaf returns a single response. A new request is taken only once the walk
// has finished, while the last response may still wait in the output register.
module optimal_split_strategy_dp #(
   parameter int MAX_LEAVES = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [osdp_pkg::LEAF_W-1:0]           req_leaf_count,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [osdp_pkg::SPLIT_W-1:0]          rsp_split,
   output logic [osdp_pkg::SPLIT_W-1:0]          rsp_strategy_length,
   output logic                                  rsp_last,
   input  logic                                  csr_write_en,
   input  logic [osdp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [osdp_pkg::CFG_W-1:0]            csr_wdata
);
   import osdp_pkg::*;

   osdp_cmd_type    cmd;
   osdp_status_type status;

   osdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status_i  (status),
      .cmd_o     (cmd)
   );

   osdp_datapath #(
      .MAX_LEAVES (MAX_LEAVES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_leaf_count      (req_leaf_count),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_split           (rsp_split),
      .rsp_strategy_length (rsp_strategy_length),
      .rsp_last            (rsp_last),
      .cmd_i               (cmd),
      .status_o            (status)
   );

endmodule
